// ----- design/bmf_pkg.sv -----
// ----------------------------------------------------------------------------
// bmf_pkg: shared definitions for the 3x3 RGB box mean filter
// Frame size limits, register indexes, reset values and the reciprocal of nine.
// ----------------------------------------------------------------------------
package bmf_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int LINE_ADDR_W = $clog2(MAX_WIDTH);

    localparam int CFG_W       = 12;
    localparam int COORD_W     = 11;
    localparam int SAMPLE_W    = 8;
    localparam int COLSUM_W    = 10;
    localparam int SUM_W       = 12;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;
    localparam logic [CFG_W-1:0] SIZE_MIN           = 12'd3;

    // floor(s * 7282 / 2^16) == floor(s / 9) for all s below 2^12
    localparam int RECIP_W = 13;
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
    localparam int RECIP_SHIFT = 16;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } pixel_t;

    function automatic logic [CFG_W-1:0] clamp_size(
        input logic [CFG_W-1:0] v,
        input logic [CFG_W-1:0] hi
    );
        logic [CFG_W-1:0] r;
        if (v < SIZE_MIN)
        begin
            r = SIZE_MIN;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- design/box_mean_filter_3x3_rgb.sv -----
// ----------------------------------------------------------------------------
// box_mean_filter_3x3_rgb: 3x3 box mean filter over an RGB raster stream
// A two-row line store and a window of column sums give the per-channel mean of
// the nine samples around each interior pixel; border pixels give no item.
//
//   channel  signals                                     handshake
//   in       blue_in green_in red_in                     in_valid / in_ready
//   out      blue_mean green_mean red_mean center_row    out_valid / out_ready
//            center_column frame_done
//   cfg      cfg_index cfg_data                          cfg_we (no wait)
//
// One pixel is accepted every cycle while no result is held. The pixel that
// completes a window is held in stage 1, its result in the output register.
// The line store is read at acceptance and written when the pixel leaves the
// second stage. Reset loads 640 x 480 and clears counters and window; the
// line store needs no clearing. A held result stalls stage 1 and then the input.
// ----------------------------------------------------------------------------
module box_mean_filter_3x3_rgb (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bmf_pkg::SAMPLE_W-1:0]    blue_in,
    input  logic [bmf_pkg::SAMPLE_W-1:0]    green_in,
    input  logic [bmf_pkg::SAMPLE_W-1:0]    red_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bmf_pkg::SAMPLE_W-1:0]    blue_mean,
    output logic [bmf_pkg::SAMPLE_W-1:0]    green_mean,
    output logic [bmf_pkg::SAMPLE_W-1:0]    red_mean,
    output logic [bmf_pkg::COORD_W-1:0]     center_row,
    output logic [bmf_pkg::COORD_W-1:0]     center_column,
    output logic                            frame_done
);
    import bmf_pkg::*;

    localparam int MUL_W = SUM_W + RECIP_W;

    logic [CFG_W-1:0]       width_reg;
    logic [CFG_W-1:0]       height_reg;
    logic [CFG_W-1:0]       width_eff;
    logic [CFG_W-1:0]       height_eff;

    logic [COORD_W-1:0]     row_reg;
    logic [COORD_W-1:0]     col_reg;
    logic [COORD_W-1:0]     row_next;
    logic [COORD_W-1:0]     col_next;

    logic [2*$bits(pixel_t)-1:0] line_mem [MAX_WIDTH];
    logic [2*$bits(pixel_t)-1:0] mem_rd_reg;

    logic                   accept;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    pixel_t                 s1_pix_reg;
    logic [COORD_W-1:0]     s1_row_reg;
    logic [COORD_W-1:0]     s1_col_reg;
    logic                   s1_produce_reg;
    logic                   s1_last_reg;
    logic                   s1_go;

    logic [COLSUM_W-1:0]    cs_old_reg [3];
    logic [COLSUM_W-1:0]    cs_new_reg [3];
    logic [COLSUM_W-1:0]    colsum [3];
    logic [SUM_W-1:0]       total [3];
    logic [MUL_W-1:0]       prod [3];
    logic [SAMPLE_W-1:0]    mean [3];

    pixel_t                 top;
    pixel_t                 mid;
    logic [SAMPLE_W-1:0]    top_ch [3];
    logic [SAMPLE_W-1:0]    mid_ch [3];
    logic [SAMPLE_W-1:0]    cur_ch [3];

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_W-1:0]    mean_reg [3];
    logic [COORD_W-1:0]     center_row_reg;
    logic [COORD_W-1:0]     center_col_reg;
    logic                   frame_done_reg;

    assign width_eff  = clamp_size(width_reg, CFG_W'(MAX_WIDTH));
    assign height_eff = clamp_size(height_reg, CFG_W'(MAX_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RESET;
            height_reg <= IMAGE_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // stage A: accept, read line store, advance raster counters
    assign s1_go    = s1_valid_reg && (!s1_produce_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg + COORD_W'(1);
        if ({1'b0, col_reg} + CFG_W'(1) >= width_eff)
        begin
            col_next = '0;
            if ({1'b0, row_reg} + CFG_W'(1) >= height_eff)
            begin
                row_next = '0;
            end
            else
            begin
                row_next = row_reg + COORD_W'(1);
            end
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg     <= '{red: red_in, green: green_in, blue: blue_in};
            s1_row_reg     <= row_reg;
            s1_col_reg     <= col_reg;
            s1_produce_reg <= (row_reg >= COORD_W'(2)) && (col_reg >= COORD_W'(2));
            s1_last_reg    <= ({1'b0, row_reg} == height_eff - CFG_W'(1))
                           && ({1'b0, col_reg} == width_eff - CFG_W'(1));
            mem_rd_reg     <= line_mem[col_reg[LINE_ADDR_W-1:0]];
        end
        if (s1_go)
        begin
            line_mem[s1_col_reg[LINE_ADDR_W-1:0]] <= {s1_pix_reg, mid};
        end
    end

    // stage 1: column sums, window sum, divide by nine
    assign mid = pixel_t'(mem_rd_reg[2*$bits(pixel_t)-1:$bits(pixel_t)]);
    assign top = pixel_t'(mem_rd_reg[$bits(pixel_t)-1:0]);

    always_comb
    begin
        top_ch[0] = top.blue;
        top_ch[1] = top.green;
        top_ch[2] = top.red;
        mid_ch[0] = mid.blue;
        mid_ch[1] = mid.green;
        mid_ch[2] = mid.red;
        cur_ch[0] = s1_pix_reg.blue;
        cur_ch[1] = s1_pix_reg.green;
        cur_ch[2] = s1_pix_reg.red;
        for (int k = 0; k < 3; k++)
        begin
            colsum[k] = COLSUM_W'(top_ch[k]) + COLSUM_W'(mid_ch[k]) + COLSUM_W'(cur_ch[k]);
            total[k]  = SUM_W'(colsum[k]) + SUM_W'(cs_new_reg[k]) + SUM_W'(cs_old_reg[k]);
            prod[k]   = MUL_W'(total[k]) * MUL_W'(RECIP_NINE);
            mean[k]   = prod[k][RECIP_SHIFT +: SAMPLE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cs_old_reg[k] <= '0;
                cs_new_reg[k] <= '0;
            end
        end
        else if (s1_go)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cs_old_reg[k] <= cs_new_reg[k];
                cs_new_reg[k] <= colsum[k];
            end
        end
    end

    // output register
    always_comb
    begin
        if (s1_go && s1_produce_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_produce_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mean_reg[k] <= mean[k];
            end
            center_row_reg <= s1_row_reg - COORD_W'(1);
            center_col_reg <= s1_col_reg - COORD_W'(1);
            frame_done_reg <= s1_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign blue_mean     = mean_reg[0];
    assign green_mean    = mean_reg[1];
    assign red_mean      = mean_reg[2];
    assign center_row    = center_row_reg;
    assign center_column = center_col_reg;
    assign frame_done    = frame_done_reg;

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_produce_reg |=> out_valid_reg)
        else $error("result from stage 1 not registered");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item lost before stage 1");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_col_reg) && $stable(mem_rd_reg))
        else $error("stalled stage 1 item changed");

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |-> !in_ready)
        else $error("input taken while stage 1 is stalled");

endmodule
